// ===== rtl/core/base3_product_carry_statistics_top_defines.svh =====
// ============================================================================
// Assertion macros for the base-3 product carry statistics block
// Each macro checks on the rising edge of clk and stays quiet during reset.
// ============================================================================
`ifndef BASE3_PRODUCT_CARRY_STATISTICS_TOP_DEFINES_SVH
`define BASE3_PRODUCT_CARRY_STATISTICS_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define B3PCS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A plain condition that must hold at every clock edge outside reset.
`define B3PCS_ASSERT_ALWAYS(label, cond, msg) \
    `B3PCS_ASSERT_CLK(label, (cond), msg)

`endif

// ===== rtl/core/b3pcs_pkg.sv =====
// ============================================================================
// b3pcs_pkg
// Shared constants, types and divide-by-three helpers of the block.
// ============================================================================
package b3pcs_pkg;

    localparam int MAX_DIGITS  = 12;
    localparam int TOTAL_WIDTH = 48;
    localparam int OPND_W      = 20;
    localparam int K_W         = 4;
    localparam int FIELD_W     = 5;
    localparam int OUT_TOTAL_W = 48;
    localparam int DIGIT_W     = 2;

    localparam logic [K_W-1:0] K_MIN   = K_W'(2);
    localparam logic [K_W-1:0] K_MAX   = K_W'(MAX_DIGITS);
    localparam logic [K_W-1:0] K_RESET = K_W'(2);

    localparam int NUM_CONV  = 2 * MAX_DIGITS - 1;
    localparam int CONV_MAX  = 4 * MAX_DIGITS;
    localparam int CONV_W    = $clog2(CONV_MAX + 1);
    localparam int CARRY_W   = $clog2(CONV_MAX / 2 + 1);
    localparam int SUM_W     = $clog2(CONV_MAX + CONV_MAX / 2 + 1);
    localparam int POS_SLOTS = 2 * MAX_DIGITS + 5;
    localparam int SCAN_POS  = POS_SLOTS - 1;
    localparam int POS_W     = $clog2(SCAN_POS);

    localparam int CHAIN_STEP   = 4;
    localparam int CHAIN_STAGES = (SCAN_POS + CHAIN_STEP - 1) / CHAIN_STEP;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int OPND_SH = OPND_W + 1;
    localparam logic [OPND_W:0] OPND_RECIP = (OPND_W + 1)'(((2 ** OPND_SH) + 2) / 3);
    localparam int SUM_SH = SUM_W + 1;
    localparam logic [SUM_W:0] SUM_RECIP = (SUM_W + 1)'(((2 ** SUM_SH) + 2) / 3);

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;
    typedef logic [NUM_CONV-1:0][CONV_W-1:0] conv_vec_t;

    typedef struct packed {
        logic      clear;
        conv_vec_t conv;
    } conv_beat_t;

    function automatic logic [OPND_W-1:0] opnd_div3(input logic [OPND_W-1:0] v);
        logic [2*OPND_W:0] prod;
        prod = {{(OPND_W + 1){1'b0}}, v} * {{OPND_W{1'b0}}, OPND_RECIP};
        return prod[OPND_SH +: OPND_W];
    endfunction

    function automatic logic [SUM_W-1:0] sum_div3(input logic [SUM_W-1:0] v);
        logic [2*SUM_W:0] prod;
        prod = {{(SUM_W + 1){1'b0}}, v} * {{SUM_W{1'b0}}, SUM_RECIP};
        return prod[SUM_SH +: SUM_W];
    endfunction

endpackage

// ===== rtl/core/base3_product_carry_statistics_top.sv =====
// ============================================================================
// base3_product_carry_statistics_top
// Takes one operand pair per clock and returns, for each pair, the highest
// nonzero base-3 carry of the digit-wise product of the low num_digits digits
// of both operands, the carries at and one below that position, and the
// saturating count and sum totals after that pair. The block sustains one
// pair per cycle while no stall holds it: the front splits off one base-3
// digit per stage over twelve stages and folds it into the digit
// convolution, a four-entry queue follows, and the back runs the carry chain
// four positions per stage over seven stages before the output register,
// where the totals live. A stalled output holds the back; the queue lets the
// front keep taking pairs until it fills. num_digits may be written only
// while no pair is in flight.
// ============================================================================
module base3_product_carry_statistics_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [b3pcs_pkg::K_W-1:0]          num_digits,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [b3pcs_pkg::OPND_W-1:0]       x_value,
    input  logic [b3pcs_pkg::OPND_W-1:0]       y_value,
    input  logic                               clear_totals,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               pair_valid,
    output logic [b3pcs_pkg::FIELD_W-1:0]      top_position,
    output logic [b3pcs_pkg::FIELD_W-1:0]      top_carry,
    output logic [b3pcs_pkg::FIELD_W-1:0]      below_top_carry,
    output logic [b3pcs_pkg::OUT_TOTAL_W-1:0]  valid_count,
    output logic [b3pcs_pkg::OUT_TOTAL_W-1:0]  carry_sum
);
    import b3pcs_pkg::*;

    logic       fq_valid;
    logic       fq_stall;
    conv_beat_t fq_beat;
    logic       qb_valid;
    logic       qb_stall;
    conv_beat_t qb_beat;

    b3pcs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .num_digits   (num_digits),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_value      (x_value),
        .y_value      (y_value),
        .clear_totals (clear_totals),
        .q_valid      (fq_valid),
        .q_stall      (fq_stall),
        .q_beat       (fq_beat)
    );

    b3pcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_beat  (fq_beat),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_beat  (qb_beat)
    );

    b3pcs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (qb_valid),
        .q_stall         (qb_stall),
        .q_beat          (qb_beat),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pair_valid      (pair_valid),
        .top_position    (top_position),
        .top_carry       (top_carry),
        .below_top_carry (below_top_carry),
        .valid_count     (valid_count),
        .carry_sum       (carry_sum)
    );

endmodule

// ===== rtl/core/b3pcs_queue.sv =====
// ============================================================================
// b3pcs_queue
// Short queue of convolution beats between the front and the back pipelines.
// ============================================================================
`include "base3_product_carry_statistics_top_defines.svh"

module b3pcs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_stall,
    input  b3pcs_pkg::conv_beat_t wr_beat,
    output logic                  rd_valid,
    input  logic                  rd_stall,
    output b3pcs_pkg::conv_beat_t rd_beat
);
    import b3pcs_pkg::*;

    conv_beat_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               push;
    logic               pop;

    assign wr_stall = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;
    assign rd_beat  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            2'b00:   count_next = count_reg;
            2'b11:   count_next = count_reg;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_beat;
        end
    end

    `B3PCS_ASSERT_CLK(a_queue_drain, (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1), "Queue fill did not drop by one on a lone read.")

endmodule

// ===== rtl/core/b3pcs_front.sv =====
// ============================================================================
// b3pcs_front
// Takes operand pairs, splits them into base-3 digits and builds the digit
// convolution of their product, one digit per stage.
// ============================================================================
`include "base3_product_carry_statistics_top_defines.svh"

module b3pcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [b3pcs_pkg::K_W-1:0]     num_digits,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [b3pcs_pkg::OPND_W-1:0]  x_value,
    input  logic [b3pcs_pkg::OPND_W-1:0]  y_value,
    input  logic                          clear_totals,
    output logic                          q_valid,
    input  logic                          q_stall,
    output b3pcs_pkg::conv_beat_t         q_beat
);
    import b3pcs_pkg::*;

    localparam int LAST = MAX_DIGITS - 1;

    function automatic conv_vec_t conv_add(input conv_vec_t acc, input digits_t dx,
                                           input digits_t dy, input int t);
        conv_vec_t              r;
        logic [2*DIGIT_W-1:0]   pa;
        logic [2*DIGIT_W-1:0]   pb;
        r = acc;
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (j <= t)
            begin
                pa = dx[t] * dy[j];
                pb = (j < t) ? dx[j] * dy[t] : '0;
                r[t + j] = r[t + j] + CONV_W'(pa) + CONV_W'(pb);
            end
        end
        return r;
    endfunction

    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    k_eff;
    logic              adv;

    logic              dig_valid_reg [MAX_DIGITS];
    logic              clr_reg       [MAX_DIGITS];
    logic [OPND_W-1:0] x_rem_reg     [MAX_DIGITS];
    logic [OPND_W-1:0] y_rem_reg     [MAX_DIGITS];
    digits_t           x_dig_reg     [MAX_DIGITS];
    digits_t           y_dig_reg     [MAX_DIGITS];
    conv_vec_t         conv_reg      [MAX_DIGITS];

    logic              conv_valid_reg;
    conv_beat_t        conv_beat_reg;
    conv_vec_t         conv_final;

    assign cfg_ready = 1'b1;
    assign adv       = !conv_valid_reg || !q_stall;
    assign in_stall  = !adv;
    assign q_valid   = conv_valid_reg;
    assign q_beat    = conv_beat_reg;

    always_comb
    begin
        priority if (k_reg < K_MIN)
        begin
            k_eff = K_MIN;
        end
        else if (k_reg > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            k_reg <= num_digits;
        end
    end

    for (genvar s = 0; s < MAX_DIGITS; s++)
    begin : g_dig
        logic [OPND_W-1:0] x_src;
        logic [OPND_W-1:0] y_src;
        logic [OPND_W-1:0] x_rem_next;
        logic [OPND_W-1:0] y_rem_next;
        logic [OPND_W-1:0] x_rmd;
        logic [OPND_W-1:0] y_rmd;
        digits_t           x_dsrc;
        digits_t           y_dsrc;
        digits_t           x_dig_next;
        digits_t           y_dig_next;
        conv_vec_t         conv_next;
        logic              valid_next;
        logic              clr_next;
        logic              keep;

        if (s == 0)
        begin : g_head
            assign x_src      = x_value;
            assign y_src      = y_value;
            assign x_dsrc     = '0;
            assign y_dsrc     = '0;
            assign conv_next  = '0;
            assign valid_next = in_valid;
            assign clr_next   = clear_totals;
        end
        else
        begin : g_body
            assign x_src      = x_rem_reg[s-1];
            assign y_src      = y_rem_reg[s-1];
            assign x_dsrc     = x_dig_reg[s-1];
            assign y_dsrc     = y_dig_reg[s-1];
            assign conv_next  = conv_add(conv_reg[s-1], x_dig_reg[s-1], y_dig_reg[s-1], s - 1);
            assign valid_next = dig_valid_reg[s-1];
            assign clr_next   = clr_reg[s-1];
        end

        assign x_rem_next = opnd_div3(x_src);
        assign y_rem_next = opnd_div3(y_src);
        assign x_rmd      = x_src - (x_rem_next + {x_rem_next[OPND_W-2:0], 1'b0});
        assign y_rmd      = y_src - (y_rem_next + {y_rem_next[OPND_W-2:0], 1'b0});
        assign keep       = (K_W'(s) < k_eff);

        always_comb
        begin
            x_dig_next = x_dsrc;
            y_dig_next = y_dsrc;
            if (keep)
            begin
                x_dig_next[s] = x_rmd[DIGIT_W-1:0];
                y_dig_next[s] = y_rmd[DIGIT_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dig_valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                dig_valid_reg[s] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_rem_reg[s] <= x_rem_next;
                y_rem_reg[s] <= y_rem_next;
                x_dig_reg[s] <= x_dig_next;
                y_dig_reg[s] <= y_dig_next;
                conv_reg[s]  <= conv_next;
                clr_reg[s]   <= clr_next;
            end
        end
    end

    assign conv_final = conv_add(conv_reg[LAST], x_dig_reg[LAST], y_dig_reg[LAST], LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            conv_valid_reg <= dig_valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            conv_beat_reg.clear <= clr_reg[LAST];
            conv_beat_reg.conv  <= conv_final;
        end
    end

    `B3PCS_ASSERT_CLK(a_front_take, (in_valid && !in_stall) |=> dig_valid_reg[0], "An accepted pair did not enter the digit pipeline.")

endmodule

// ===== rtl/core/b3pcs_back.sv =====
// ============================================================================
// b3pcs_back
// Runs the base-3 carry chain four positions per stage, tracks the highest
// nonzero carry and updates the saturating totals in the output register.
// ============================================================================
`include "base3_product_carry_statistics_top_defines.svh"

module b3pcs_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_stall,
    input  b3pcs_pkg::conv_beat_t              q_beat,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               pair_valid,
    output logic [b3pcs_pkg::FIELD_W-1:0]      top_position,
    output logic [b3pcs_pkg::FIELD_W-1:0]      top_carry,
    output logic [b3pcs_pkg::FIELD_W-1:0]      below_top_carry,
    output logic [b3pcs_pkg::OUT_TOTAL_W-1:0]  valid_count,
    output logic [b3pcs_pkg::OUT_TOTAL_W-1:0]  carry_sum
);
    import b3pcs_pkg::*;

    typedef struct packed {
        logic               clear;
        conv_vec_t          conv;
        logic [CARRY_W-1:0] carry;
        logic [CARRY_W-1:0] prev;
        logic [POS_W-1:0]   top;
        logic [CARRY_W-1:0] top_c;
        logic [CARRY_W-1:0] below_c;
    } chain_t;

    function automatic chain_t chain_step(input chain_t st, input int base);
        chain_t           r;
        logic [SUM_W-1:0] s;
        int               p;
        r = st;
        for (int n = 0; n < CHAIN_STEP; n++)
        begin
            p = base + n;
            if (p < SCAN_POS)
            begin
                if ((p >= 1) && (r.carry != '0))
                begin
                    r.top     = POS_W'(p);
                    r.top_c   = r.carry;
                    r.below_c = r.prev;
                end
                s       = SUM_W'(r.conv[0]) + SUM_W'(r.carry);
                r.conv  = r.conv >> CONV_W;
                r.prev  = r.carry;
                r.carry = CARRY_W'(sum_div3(s));
            end
        end
        return r;
    endfunction

    logic                   adv;
    chain_t                 chain_init;
    logic                   chain_valid_reg [CHAIN_STAGES];
    chain_t                 chain_reg       [CHAIN_STAGES];
    chain_t                 last;
    logic                   last_valid;
    logic                   hit;

    logic                   out_valid_reg;
    logic                   pair_valid_reg;
    logic [POS_W-1:0]       top_reg;
    logic [CARRY_W-1:0]     tc_reg;
    logic [CARRY_W-1:0]     bc_reg;
    logic [TOTAL_WIDTH-1:0] count_reg;
    logic [TOTAL_WIDTH-1:0] sum_reg;
    logic [TOTAL_WIDTH-1:0] count_next;
    logic [TOTAL_WIDTH-1:0] sum_next;
    logic [TOTAL_WIDTH-1:0] count_base;
    logic [TOTAL_WIDTH-1:0] sum_base;
    logic [TOTAL_WIDTH:0]   count_inc;
    logic [TOTAL_WIDTH:0]   sum_inc;

    assign adv     = !out_valid_reg || !out_stall;
    assign q_stall = !adv;

    always_comb
    begin
        chain_init         = '0;
        chain_init.clear   = q_beat.clear;
        chain_init.conv    = q_beat.conv;
    end

    for (genvar c = 0; c < CHAIN_STAGES; c++)
    begin : g_chain
        chain_t src;
        chain_t chain_next;
        logic   valid_next;

        if (c == 0)
        begin : g_head
            assign src        = chain_init;
            assign valid_next = q_valid;
        end
        else
        begin : g_body
            assign src        = chain_reg[c-1];
            assign valid_next = chain_valid_reg[c-1];
        end

        assign chain_next = chain_step(src, c * CHAIN_STEP);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                chain_valid_reg[c] <= 1'b0;
            end
            else if (adv)
            begin
                chain_valid_reg[c] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                chain_reg[c] <= chain_next;
            end
        end
    end

    assign last       = chain_reg[CHAIN_STAGES-1];
    assign last_valid = chain_valid_reg[CHAIN_STAGES-1];
    assign hit        = (last.top != '0);
    assign count_base = last.clear ? '0 : count_reg;
    assign sum_base   = last.clear ? '0 : sum_reg;
    assign count_inc  = {1'b0, count_base} + (TOTAL_WIDTH + 1)'(1);
    assign sum_inc    = {1'b0, sum_base} + (TOTAL_WIDTH + 1)'(last.below_c);

    always_comb
    begin
        count_next = count_base;
        sum_next   = sum_base;
        if (hit)
        begin
            count_next = count_inc[TOTAL_WIDTH] ? '1 : count_inc[TOTAL_WIDTH-1:0];
            sum_next   = sum_inc[TOTAL_WIDTH] ? '1 : sum_inc[TOTAL_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= last_valid;
            if (last_valid)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pair_valid_reg <= hit;
            top_reg        <= last.top;
            tc_reg         <= last.top_c;
            bc_reg         <= last.below_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pair_valid      = pair_valid_reg;
    assign top_position    = FIELD_W'(top_reg);
    assign top_carry       = FIELD_W'(tc_reg);
    assign below_top_carry = FIELD_W'(bc_reg);
    assign valid_count     = OUT_TOTAL_W'(count_reg);
    assign carry_sum       = OUT_TOTAL_W'(sum_reg);

    `B3PCS_ASSERT_CLK(a_back_hold, (out_valid && out_stall) |=> ($stable(count_reg) && $stable(sum_reg)), "Totals moved while the result beat was stalled.")
    `B3PCS_ASSERT_ALWAYS(a_back_flag, !out_valid_reg || (pair_valid_reg == (top_reg != '0)), "Pair flag disagrees with the top position.")
    `B3PCS_ASSERT_ALWAYS(a_back_topc, !(out_valid_reg && pair_valid_reg) || (tc_reg != '0), "A valid pair shows a zero carry at its top position.")

endmodule
